### rtl/dess_pkg.sv
// ----------------------------------------------------------------------------
// dess_pkg
// Types, constants and helpers for the DAC EEPROM store sequencer.
// ----------------------------------------------------------------------------
package dess_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BEFORE_TICKS     = 2'd0,
    CFG_AFTER_TICKS      = 2'd1,
    CFG_CYCLE_TICKS      = 2'd2,
    CFG_STORE_WAIT_TICKS = 2'd3
  } cfg_reg_t;

  localparam int HOLD_W = 8;
  localparam int WAIT_W = 20;
  localparam int COUNT_W = 16;
  localparam int ADDR_W = 7;

  localparam logic [HOLD_W-1:0] BEFORE_RESET = 8'd1;
  localparam logic [HOLD_W-1:0] AFTER_RESET  = 8'd2;
  localparam logic [HOLD_W-1:0] CYCLE_RESET  = 8'd5;
  localparam logic [WAIT_W-1:0] STORE_WAIT_RESET = 20'd10000;

  // Zero bytes sent after the address byte in the address frame
  localparam int ZERO_BYTES_DEF = 8;

  // Frames of the sequence
  localparam logic [2:0] FRAME_FIRST = 3'd0;
  localparam logic [2:0] FRAME_CMD   = 3'd1;
  localparam logic [2:0] FRAME_ADDR  = 3'd2;
  localparam logic [2:0] FRAME_WAKE  = 3'd3;
  localparam logic [2:0] FRAME_LAST  = 3'd4;

  // Payload bytes
  localparam logic [7:0] SHORT_CODE = 8'h02;  // three-bit 010 pattern
  localparam logic [7:0] CMD_BYTE   = 8'h10;
  localparam logic [7:0] STORE_BYTE = 8'h03;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  // Last bit index of a three-bit frame and of a byte with its ACK clock
  localparam logic [3:0] SHORT_LAST_BIT = 4'd2;
  localparam logic [3:0] BYTE_LAST_BIT  = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_PREP_A  = 4'd1,
    PH_PREP_B  = 4'd2,
    PH_START_A = 4'd3,
    PH_START_B = 4'd4,
    PH_START_C = 4'd5,
    PH_START_D = 4'd6,
    PH_BIT_A   = 4'd7,
    PH_BIT_B   = 4'd8,
    PH_BIT_C   = 4'd9,
    PH_STOP_A  = 4'd10,
    PH_STOP_B  = 4'd11,
    PH_STOP_C  = 4'd12,
    PH_DELAY   = 4'd13,
    PH_FINISH  = 4'd14
  } phase_t;

  // Which hold register follows an action
  typedef enum logic [2:0] {
    HOLD_NONE,
    HOLD_BEFORE,
    HOLD_AFTER,
    HOLD_CYCLE,
    HOLD_STORE
  } hold_sel_t;

  // Frames made of the three-bit pattern rather than whole bytes
  function automatic logic is_short_frame(input logic [2:0] frame);
    return (frame == FRAME_FIRST) || (frame == FRAME_WAKE);
  endfunction

  // Byte sent at the current position of a frame
  function automatic logic [7:0] item_value(input logic [2:0] frame,
                                            input logic first_byte,
                                            input logic [ADDR_W-1:0] addr);
    logic [7:0] val;
    if (is_short_frame(frame)) begin
      val = SHORT_CODE;
    end else if (frame == FRAME_ADDR) begin
      val = first_byte ? {addr, 1'b0} : ZERO_BYTE;
    end else if (first_byte) begin
      val = CMD_BYTE;
    end else begin
      val = (frame == FRAME_CMD) ? STORE_BYTE : ZERO_BYTE;
    end
    return val;
  endfunction

  // Data line level for a bit, MSB first; the ACK clock releases the line
  function automatic logic current_bit(input logic short_frame,
                                       input logic [3:0] bit_idx,
                                       input logic [7:0] val);
    logic b;
    if (short_frame) begin
      if (bit_idx > SHORT_LAST_BIT) b = 1'b1;
      else b = val[2'(SHORT_LAST_BIT - bit_idx)];
    end else begin
      if (bit_idx >= BYTE_LAST_BIT) b = 1'b1;
      else b = val[3'(4'd7 - bit_idx)];
    end
    return b;
  endfunction

endpackage

### rtl/dac_eeprom_store_sequencer.sv
// ----------------------------------------------------------------------------
// dac_eeprom_store_sequencer
// Bit-banged open-drain bus master that plays the DAC EEPROM store sequence,
// one waveform step per tick beat once the previous step's hold has run out.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-----------------------------------
//  s_        | in  | s_tvalid/s_tready  | s_tuser = kind, s_tdata = address
//  m_        | out | m_tvalid/m_tready  | m_tdata = lines, busy, done, count
//  cfg_      | in  | cfg_we             | cfg_index, cfg_data (20 bits)
//
//  One beat in per clock, one result beat out in the cycle after; the state
//  update and the result register load happen in the same cycle.
//  s_tready is low only while a result waits in the output register and
//  m_tready is low; throughput is one beat per cycle otherwise.
//  Synchronous reset restores idle state, released lines and reset hold
//  values; no clearing pass.
// ----------------------------------------------------------------------------
module dac_eeprom_store_sequencer
  import dess_pkg::*;
#(
  parameter int ZERO_BYTES = ZERO_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] chip_address, [7] zero
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] sda_released, [1] scl_released, [2] busy_res, [3] sequence_done,
  // [19:4] stores_done, [23:20] zero
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int BYTE_W = (ZERO_BYTES + 1 > 1) ? $clog2(ZERO_BYTES + 1) : 1;

  // Configuration registers
  logic [HOLD_W-1:0] before_ticks, after_ticks, cycle_ticks;
  logic [WAIT_W-1:0] store_wait_ticks;

  // Sequencer state
  phase_t             phase, phase_next;
  logic [2:0]         frame_index, frame_index_next;
  logic [BYTE_W-1:0]  byte_index, byte_index_next;
  logic [3:0]         bit_index, bit_index_next;
  logic [WAIT_W-1:0]  wait_count, wait_count_next;
  logic [ADDR_W-1:0]  latched_address, latched_address_next;
  logic [COUNT_W-1:0] store_total, store_total_next;
  logic               sda_level, sda_level_next;
  logic               scl_level, scl_level_next;
  logic               done_next;

  // Action decode
  logic        step, tick_step, act;
  hold_sel_t   hold_sel;
  logic [WAIT_W-1:0] hold_val;
  logic        short_frame, last_bit, last_byte, bit_val;
  logic [7:0]  byte_val;

  // Output register
  logic [23:0] out_data;
  logic        out_valid;

  assign s_tready = !out_valid || m_tready;
  assign step     = s_tvalid && s_tready;
  assign tick_step = step && !s_tuser && (phase != PH_IDLE);
  // an action is performed once the hold of the previous one has run out
  assign act = tick_step && (wait_count == '0) && (phase != PH_FINISH);

  assign short_frame = is_short_frame(frame_index);
  assign byte_val    = item_value(frame_index, byte_index == '0, latched_address);
  assign bit_val     = current_bit(short_frame, bit_index, byte_val);
  assign last_bit    = short_frame ? (bit_index == SHORT_LAST_BIT)
                                   : (bit_index == BYTE_LAST_BIT);
  always_comb begin
    if (short_frame) last_byte = (byte_index == '0);
    else if (frame_index == FRAME_ADDR) last_byte = (byte_index == BYTE_W'(ZERO_BYTES));
    else last_byte = (byte_index == BYTE_W'(1));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      before_ticks     <= BEFORE_RESET;
      after_ticks      <= AFTER_RESET;
      cycle_ticks      <= CYCLE_RESET;
      store_wait_ticks <= STORE_WAIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BEFORE_TICKS:     before_ticks     <= cfg_data[HOLD_W-1:0];
        CFG_AFTER_TICKS:      after_ticks      <= cfg_data[HOLD_W-1:0];
        CFG_CYCLE_TICKS:      cycle_ticks      <= cfg_data[HOLD_W-1:0];
        CFG_STORE_WAIT_TICKS: store_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next phase, indexes and counters
  always_comb begin
    phase_next           = phase;
    frame_index_next     = frame_index;
    byte_index_next      = byte_index;
    bit_index_next       = bit_index;
    latched_address_next = latched_address;
    store_total_next     = store_total;
    done_next            = 1'b0;
    if (step && s_tuser && (phase == PH_IDLE)) begin
      latched_address_next = s_tdata[ADDR_W-1:0];
      frame_index_next     = FRAME_FIRST;
      byte_index_next      = '0;
      bit_index_next       = '0;
      phase_next           = PH_PREP_A;
    end else if (tick_step && (wait_count == '0) && (phase == PH_FINISH)) begin
      phase_next       = PH_IDLE;
      store_total_next = store_total + COUNT_W'(1);
      done_next        = 1'b1;
    end else if (act) begin
      unique case (phase)
        PH_PREP_A:  phase_next = PH_PREP_B;
        PH_PREP_B:  phase_next = PH_START_A;
        PH_START_A: phase_next = PH_START_B;
        PH_START_B: phase_next = PH_START_C;
        PH_START_C: phase_next = PH_START_D;
        PH_START_D: begin
          byte_index_next = '0;
          bit_index_next  = '0;
          phase_next      = PH_BIT_A;
        end
        PH_BIT_A:   phase_next = PH_BIT_B;
        PH_BIT_B:   phase_next = PH_BIT_C;
        PH_BIT_C: begin
          if (last_bit) begin
            bit_index_next = '0;
            if (last_byte) begin
              byte_index_next = '0;
              phase_next      = PH_STOP_A;
            end else begin
              byte_index_next = byte_index + BYTE_W'(1);
              phase_next      = PH_BIT_A;
            end
          end else begin
            bit_index_next = bit_index + 4'd1;
            phase_next     = PH_BIT_A;
          end
        end
        PH_STOP_A:  phase_next = PH_STOP_B;
        PH_STOP_B:  phase_next = PH_STOP_C;
        PH_STOP_C: begin
          if (frame_index == FRAME_ADDR) begin
            phase_next = PH_DELAY;
          end else if (frame_index >= FRAME_LAST) begin
            frame_index_next = FRAME_FIRST;
            phase_next       = PH_FINISH;
          end else begin
            frame_index_next = frame_index + 3'd1;
            phase_next       = PH_START_A;
          end
        end
        PH_DELAY: begin
          frame_index_next = FRAME_WAKE;
          phase_next       = PH_START_A;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Line levels and hold selection for the action being performed
  always_comb begin
    sda_level_next = sda_level;
    scl_level_next = scl_level;
    hold_sel       = HOLD_NONE;
    if (act) begin
      unique case (phase)
        PH_PREP_A:  sda_level_next = 1'b1;
        PH_PREP_B:  begin scl_level_next = 1'b1; hold_sel = HOLD_CYCLE; end
        PH_START_A: sda_level_next = 1'b1;
        PH_START_B: begin scl_level_next = 1'b1; hold_sel = HOLD_CYCLE; end
        PH_START_C: begin sda_level_next = 1'b0; hold_sel = HOLD_CYCLE; end
        PH_START_D: begin scl_level_next = 1'b0; hold_sel = HOLD_CYCLE; end
        PH_BIT_A:   begin sda_level_next = bit_val; hold_sel = HOLD_BEFORE; end
        PH_BIT_B:   begin scl_level_next = 1'b1; hold_sel = HOLD_CYCLE; end
        PH_BIT_C:   begin scl_level_next = 1'b0; hold_sel = HOLD_AFTER; end
        PH_STOP_A:  begin sda_level_next = 1'b0; hold_sel = HOLD_BEFORE; end
        PH_STOP_B:  begin scl_level_next = 1'b1; hold_sel = HOLD_CYCLE; end
        PH_STOP_C:  begin sda_level_next = 1'b1; hold_sel = HOLD_CYCLE; end
        PH_DELAY:   hold_sel = HOLD_STORE;
        default: ;
      endcase
    end
  end

  // Hold length, then ticks left after the action's own tick
  always_comb begin
    unique case (hold_sel)
      HOLD_BEFORE: hold_val = WAIT_W'(before_ticks);
      HOLD_AFTER:  hold_val = WAIT_W'(after_ticks);
      HOLD_CYCLE:  hold_val = WAIT_W'(cycle_ticks);
      HOLD_STORE:  hold_val = store_wait_ticks;
      default:     hold_val = '0;
    endcase
    if (step && s_tuser && (phase == PH_IDLE)) wait_count_next = '0;
    else if (tick_step && (wait_count != '0)) wait_count_next = wait_count - WAIT_W'(1);
    else if (act) wait_count_next = (hold_val == '0) ? '0 : hold_val - WAIT_W'(1);
    else wait_count_next = wait_count;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      frame_index     <= FRAME_FIRST;
      byte_index      <= '0;
      bit_index       <= '0;
      wait_count      <= '0;
      latched_address <= '0;
      store_total     <= '0;
      sda_level       <= 1'b1;
      scl_level       <= 1'b1;
    end else begin
      phase           <= phase_next;
      frame_index     <= frame_index_next;
      byte_index      <= byte_index_next;
      bit_index       <= bit_index_next;
      wait_count      <= wait_count_next;
      latched_address <= latched_address_next;
      store_total     <= store_total_next;
      sda_level       <= sda_level_next;
      scl_level       <= scl_level_next;
    end
  end

  // Result register: one beat out for every beat in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= {4'd0, store_total_next, done_next, phase_next != PH_IDLE,
                   scl_level_next, sda_level_next};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Checks
  a_idle_no_wait: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (wait_count == '0))
    else $error("wait count left over in idle");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (step && done_next) |=> (out_data[3] && !out_data[2]))
    else $error("sequence done reported while still busy");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (store_total != $past(store_total)) |-> (phase == PH_IDLE && $past(phase) == PH_FINISH))
    else $error("store count moved outside sequence end");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    (bit_index <= BYTE_LAST_BIT) && (frame_index <= FRAME_LAST))
    else $error("bit or frame index out of range");

  a_stall_no_take: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

endmodule
